>>> sv/r2fft_pkg.sv
package r2fft_pkg;

	localparam int SAMPLE_W = 16;
	localparam int BIN_W = 32;
	// working width: 16-bit input grows at most one bit per stage plus rounding
	localparam int ACC_W = 24;
	localparam int TW_W = 17;
	localparam int SIZE_W = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2 = 1'd1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_real;
		logic [SAMPLE_W-1:0] sample_imag;
	} sample_t;

	typedef struct packed {
		logic [BIN_W-1:0] bin_real;
		logic [BIN_W-1:0] bin_imag;
		logic             last_bin;
	} bin_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [SIZE_W-1:0]    value;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // write input sample at addr_a
		logic       bfly;      // butterfly on addr_a / addr_b
		logic       rd;        // issue read of addr_a for output
		logic [5:0] addr_a;
		logic [5:0] addr_b;
		logic [4:0] tw_k;      // twiddle index in 64ths of a turn, 0..31
		logic       inverse;
		logic [2:0] lg;
	} dp_cmd_t;

	function automatic logic signed [TW_W-1:0] cos_rom(input logic [4:0] k);
		case (k)
			5'd0: cos_rom = 17'sd32767;
			5'd1: cos_rom = 17'sd32610;
			5'd2: cos_rom = 17'sd32138;
			5'd3: cos_rom = 17'sd31357;
			5'd4: cos_rom = 17'sd30274;
			5'd5: cos_rom = 17'sd28899;
			5'd6: cos_rom = 17'sd27246;
			5'd7: cos_rom = 17'sd25330;
			5'd8: cos_rom = 17'sd23170;
			5'd9: cos_rom = 17'sd20788;
			5'd10: cos_rom = 17'sd18205;
			5'd11: cos_rom = 17'sd15447;
			5'd12: cos_rom = 17'sd12540;
			5'd13: cos_rom = 17'sd9512;
			5'd14: cos_rom = 17'sd6393;
			5'd15: cos_rom = 17'sd3212;
			default: cos_rom = 17'sd0;
		endcase
	endfunction

	function automatic logic signed [TW_W-1:0] tw_cos(input logic [4:0] k);
		if (k <= 5'd16) tw_cos = cos_rom(k);
		else tw_cos = -cos_rom(5'(6'd32 - 6'(k)));
	endfunction

	function automatic logic signed [TW_W-1:0] tw_sin(input logic [4:0] k);
		if (k <= 5'd16) tw_sin = cos_rom(5'(5'd16 - k));
		else tw_sin = cos_rom(5'(k - 5'd16));
	endfunction

	function automatic logic [5:0] bit_rev(input logic [5:0] x, input logic [2:0] bits);
		logic [5:0] r;
		r = '0;
		for (int i = 0; i < 6; i++)
			if (i < int'(bits)) r[int'(bits) - 1 - i] = x[i];
		bit_rev = r;
	endfunction

endpackage

>>> sv/r2fft_if.sv
interface r2fft_sample_if;
	import r2fft_pkg::*;
	logic    valid;
	logic    ready;
	sample_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface r2fft_bin_if;
	import r2fft_pkg::*;
	logic valid;
	logic ready;
	bin_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface r2fft_cfg_if;
	import r2fft_pkg::*;
	logic valid;
	logic ready;
	cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> sv/radix2_fft_ifft_unit.sv
// channel   dir  payload                               transaction when
// s_sample  in   sample_real, sample_imag              valid && ready
// m_bin     out  bin_real, bin_imag, last_bin          valid && ready
// s_cfg     in   index (0 inverse_mode, 1 size_log2)   valid && ready (always ready)
// a frame of n = 2^L points: n samples loaded, then L stages of n/2 butterflies,
// one butterfly per cycle, each stage followed by a drain, then n bins emitted,
// each from a registered read; a bin's read is issued only once the previous
// read has landed and the output register is empty or being taken
// arst_n clears control state; memory contents are not cleared
// loading stops while a frame is computed or emitted; output stalls hold the bins
module radix2_fft_ifft_unit #(
	parameter int MAX_POINTS = 64
) (
	input logic clk,
	input logic arst_n,
	r2fft_sample_if.sink s_sample,
	r2fft_bin_if.source  m_bin,
	r2fft_cfg_if.sink    s_cfg
);
	import r2fft_pkg::*;

	dp_cmd_t cmd;
	logic out_valid, out_last;
	logic signed [BIN_W-1:0] rd_real, rd_imag;
	logic [BIN_W-1:0] re_q, im_q;
	logic ld_q;

	r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_sample.valid), .in_ready(s_sample.ready),
		.cfg_valid(s_cfg.valid), .cfg(s_cfg.payload),
		.out_ready(m_bin.ready), .out_valid(out_valid), .out_last(out_last),
		.cmd(cmd)
	);

	r2fft_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sample(s_sample.payload),
		.rd_real(rd_real), .rd_imag(rd_imag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ld_q <= 1'b0;
		else ld_q <= cmd.rd;
	end

	always_ff @(posedge clk) begin
		if (ld_q) begin
			re_q <= rd_real;
			im_q <= rd_imag;
		end
	end

	assign s_cfg.ready = 1'b1;
	assign m_bin.valid = out_valid;
	assign m_bin.payload.bin_real = ld_q ? rd_real : re_q;
	assign m_bin.payload.bin_imag = ld_q ? rd_imag : im_q;
	assign m_bin.payload.last_bin = out_last;

endmodule

>>> sv/r2fft_datapath.sv
module r2fft_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  r2fft_pkg::dp_cmd_t          cmd,
	input  r2fft_pkg::sample_t          sample,
	output logic signed [r2fft_pkg::BIN_W-1:0] rd_real,
	output logic signed [r2fft_pkg::BIN_W-1:0] rd_imag
);
	import r2fft_pkg::*;

	logic signed [ACC_W-1:0] mem_re [64];
	logic signed [ACC_W-1:0] mem_im [64];

	// butterfly pipeline: s1 = read, s2 = multiply, s3 = write
	logic                    bf_s1, bf_s2;
	logic [5:0]              a_s1, b_s1, a_s2, b_s2;
	logic signed [TW_W-1:0]  wr_s1, wi_s1;
	logic signed [ACC_W-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [ACC_W-1:0] ar_s2, ai_s2;
	logic signed [ACC_W+TW_W:0] tr_s2, ti_s2;
	logic signed [ACC_W-1:0] tr, ti;
	logic                    inv_s1;
	logic [2:0]              lg_s1;
	logic signed [ACC_W-1:0] ra, ia;
	logic signed [ACC_W:0]   vr, vi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_s1 <= 1'b0;
			bf_s2 <= 1'b0;
		end else begin
			bf_s1 <= cmd.bfly;
			bf_s2 <= bf_s1;
		end
	end

	always_ff @(posedge clk) begin
		ar_s1 <= mem_re[cmd.addr_a];
		ai_s1 <= mem_im[cmd.addr_a];
		br_s1 <= mem_re[cmd.addr_b];
		bi_s1 <= mem_im[cmd.addr_b];
		a_s1 <= cmd.addr_a;
		b_s1 <= cmd.addr_b;
		wr_s1 <= tw_cos(cmd.tw_k);
		wi_s1 <= cmd.inverse ? -tw_sin(cmd.tw_k) : tw_sin(cmd.tw_k);
		inv_s1 <= cmd.inverse;
		lg_s1 <= cmd.lg;
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		ar_s2 <= ar_s1;
		ai_s2 <= ai_s1;
		tr_s2 <= (ACC_W+TW_W+1)'(br_s1) * (ACC_W+TW_W+1)'(wr_s1)
			- (ACC_W+TW_W+1)'(bi_s1) * (ACC_W+TW_W+1)'(wi_s1)
			+ (ACC_W+TW_W+1)'(16384);
		ti_s2 <= (ACC_W+TW_W+1)'(br_s1) * (ACC_W+TW_W+1)'(wi_s1)
			+ (ACC_W+TW_W+1)'(bi_s1) * (ACC_W+TW_W+1)'(wr_s1)
			+ (ACC_W+TW_W+1)'(16384);
		if (cmd.load) begin
			mem_re[cmd.addr_a] <= ACC_W'(signed'(sample.sample_real));
			mem_im[cmd.addr_a] <= ACC_W'(signed'(sample.sample_imag));
		end else if (bf_s2) begin
			mem_re[a_s2] <= ar_s2 + tr;
			mem_im[a_s2] <= ai_s2 + ti;
			mem_re[b_s2] <= ar_s2 - tr;
			mem_im[b_s2] <= ai_s2 - ti;
		end
	end

	assign tr = ACC_W'(tr_s2 >>> 15);
	assign ti = ACC_W'(ti_s2 >>> 15);

	// output scaling from the s1 read
	assign ra = ar_s1;
	assign ia = ai_s1;
	always_comb begin
		vr = (ACC_W+1)'(ra);
		vi = (ACC_W+1)'(ia);
		if (inv_s1 && lg_s1 != 3'd0) begin
			vr = (vr + ((ACC_W+1)'(1) <<< (lg_s1 - 3'd1))) >>> lg_s1;
			vi = (vi + ((ACC_W+1)'(1) <<< (lg_s1 - 3'd1))) >>> lg_s1;
		end
		rd_real = BIN_W'(vr);
		rd_imag = BIN_W'(vi);
	end

endmodule

>>> sv/r2fft_ctrl.sv
module r2fft_ctrl #(
	parameter int MAX_POINTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cfg_valid,
	input  r2fft_pkg::cfg_t      cfg,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 out_last,
	output r2fft_pkg::dp_cmd_t   cmd
);
	import r2fft_pkg::*;

	// largest usable log2 size: floor(log2(MAX_POINTS))
	localparam logic [2:0] LG_MAX = 3'($clog2(MAX_POINTS + 1) - 1);

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_BFLY = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t     state_q;
	logic       inverse_q;
	logic [2:0] size_q;
	logic [6:0] count_q;
	logic [2:0] stage_q;
	logic [4:0] idx_q;      // butterfly index within a stage
	logic [1:0] drain_q;
	logic [6:0] emit_q;
	logic       rd_pend_q;
	logic       out_valid_q, last_q;
	logic [2:0] lg;
	logic [6:0] n;
	logic       in_fire, rd_issue;
	logic [5:0] half, j, grp, a;

	assign lg = (size_q > LG_MAX) ? LG_MAX : size_q;
	assign n = 7'd1 << lg;
	assign in_ready = (state_q == ST_LOAD);
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_last = last_q;

	// butterfly addressing for stage s (1-based stage_q+1)
	assign half = 6'd1 << stage_q;
	assign j = 6'(idx_q) & (half - 6'd1);
	assign grp = (6'(idx_q) >> stage_q) << (stage_q + 3'd1);
	assign a = grp + j;

	// one read in flight feeding the output register; issue when it will have room
	assign rd_issue = (state_q == ST_EMIT) && (emit_q < n) && !rd_pend_q
		&& (!out_valid_q || out_ready);

	always_comb begin
		cmd = '0;
		cmd.inverse = inverse_q;
		cmd.lg = lg;
		cmd.load = in_fire;
		case (state_q)
			ST_LOAD: cmd.addr_a = bit_rev(count_q[5:0], lg);
			ST_BFLY: begin
				cmd.bfly = 1'b1;
				cmd.addr_a = a;
				cmd.addr_b = a + half;
				cmd.tw_k = 5'((j << (3'd5 - stage_q)));
			end
			ST_EMIT: begin
				cmd.rd = rd_issue;
				cmd.addr_a = emit_q[5:0];
			end
			default: cmd.addr_a = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			inverse_q <= 1'b0;
			size_q <= 3'd6;
			count_q <= '0;
			stage_q <= '0;
			idx_q <= '0;
			drain_q <= '0;
			emit_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg.index == REG_INVERSE_MODE) inverse_q <= cfg.value[0];
				else begin
					size_q <= cfg.value;
					count_q <= '0;
				end
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (rd_pend_q) begin
				out_valid_q <= 1'b1;
				last_q <= (emit_q == n);
				rd_pend_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: if (in_fire) begin
					if (count_q + 7'd1 >= n) begin
						count_q <= '0;
						stage_q <= '0;
						idx_q <= '0;
						emit_q <= '0;
						state_q <= (lg == 3'd0) ? ST_EMIT : ST_BFLY;
					end else count_q <= count_q + 7'd1;
				end
				ST_BFLY: begin
					if (7'(idx_q) + 7'd1 >= (n >> 1)) begin
						idx_q <= '0;
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else idx_q <= idx_q + 5'd1;
				end
				// let the last writes land before the next stage or the output reads
				ST_DRAIN: begin
					if (drain_q == 2'd2) begin
						if (stage_q + 3'd1 >= lg) state_q <= ST_EMIT;
						else begin
							stage_q <= stage_q + 3'd1;
							state_q <= ST_BFLY;
						end
					end else drain_q <= drain_q + 2'd1;
				end
				ST_EMIT: begin
					if (rd_issue) begin
						rd_pend_q <= 1'b1;
						emit_q <= emit_q + 7'd1;
					end
					if (emit_q == n && !rd_pend_q && (!out_valid_q || out_ready))
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

>>> sv/r2fft_checker.sv
module r2fft_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);
	a_no_load_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("load during emit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("bin dropped");
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_last)) else $error("last changed");
endmodule

bind radix2_fft_ifft_unit r2fft_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_ready(s_sample.ready),
	.out_valid(m_bin.valid), .out_ready(m_bin.ready), .out_last(m_bin.payload.last_bin)
);

>>> test/radix2_fft_ifft_unit_test.sv
`timescale 1ns / 1ps

module radix2_fft_ifft_unit_test;
	import r2fft_pkg::*;

	logic clk;
	logic arst_n;

	r2fft_sample_if s_sample ();
	r2fft_bin_if    m_bin ();
	r2fft_cfg_if    s_cfg ();

	radix2_fft_ifft_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_sample (s_sample),
		.m_bin    (m_bin),
		.s_cfg    (s_cfg)
	);

	// predictor state
	logic       inv_mode;
	logic [2:0] size_code;
	int         frame_fill;
	longint     frame_re[64];
	longint     frame_im[64];

	bin_t bin_queue[$];
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   recv_hold;
	int   hold_cycles;
	int   errors;
	bit   sample_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("[radix2_fft_ifft_unit] ERROR");
		$finish;
	end

	function automatic longint floor_sh(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat_32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rom_val(int k);
		int tab[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
			20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
		return tab[k];
	endfunction

	function automatic longint twid_cos(int k);
		k = k & 31;
		return (k <= 16) ? rom_val(k) : -rom_val(32 - k);
	endfunction

	function automatic longint twid_sin(int k);
		k = k & 31;
		return (k <= 16) ? rom_val(16 - k) : rom_val(k - 16);
	endfunction

	function automatic int active_log2();
		return (size_code > 3'd6) ? 6 : int'(size_code);
	endfunction

	// computes a whole frame once the last sample is in
	task automatic predict_sample(input sample_t smp);
		longint re[64], im[64];
		longint wr, wi, tr, ti, vr, vi;
		int lg, n, m, half, stride, a, b, r;
		bin_t o;
		lg = active_log2();
		n = 1 << lg;
		frame_re[frame_fill & 63] = longint'($signed(smp.sample_real));
		frame_im[frame_fill & 63] = longint'($signed(smp.sample_imag));
		frame_fill = (frame_fill + 1) & 127;
		if (frame_fill < n) return;
		frame_fill = 0;
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int k = 0; k < lg; k++) r = (r << 1) | ((i >> k) & 1);
			re[i] = frame_re[r];
			im[i] = frame_im[r];
		end
		for (int s = 1; s <= lg; s++) begin
			m = 1 << s;
			half = m >> 1;
			stride = 64 >> s;
			for (int g = 0; g < n; g += m) begin
				for (int j = 0; j < half; j++) begin
					a = g + j;
					b = a + half;
					wr = twid_cos(j * stride);
					wi = twid_sin(j * stride);
					if (inv_mode) wi = -wi;
					tr = floor_sh(re[b] * wr - im[b] * wi + 16384, 15);
					ti = floor_sh(re[b] * wi + im[b] * wr + 16384, 15);
					re[b] = re[a] - tr;
					im[b] = im[a] - ti;
					re[a] = re[a] + tr;
					im[a] = im[a] + ti;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			vr = re[i];
			vi = im[i];
			if (inv_mode && lg > 0) begin
				vr = floor_sh(vr + (64'sd1 << (lg - 1)), lg);
				vi = floor_sh(vi + (64'sd1 << (lg - 1)), lg);
			end
			o.bin_real = 32'(sat_32(vr));
			o.bin_imag = 32'(sat_32(vi));
			o.last_bin = (i == n - 1);
			bin_queue = {bin_queue, o};
		end
	endtask

	task automatic drop_valid();
		if (sample_on) begin
			s_sample.valid <= 1'b0;
			sample_on = 1'b0;
		end
	endtask

	task automatic send_sample(input logic [15:0] re, input logic [15:0] im);
		sample_t smp;
		while ($urandom_range(99) < send_idle_pct) begin
			drop_valid();
			@(posedge clk);
		end
		smp.sample_real = re;
		smp.sample_imag = im;
		s_sample.valid <= 1'b1;
		s_sample.payload <= smp;
		sample_on = 1'b1;
		do @(posedge clk); while (!s_sample.ready);
		predict_sample(smp);
	endtask

	task automatic wait_drained();
		drop_valid();
		while (bin_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] val);
		cfg_t c;
		wait_drained();
		c.index = idx;
		c.value = val;
		s_cfg.valid <= 1'b1;
		s_cfg.payload <= c;
		do @(posedge clk); while (!s_cfg.ready);
		s_cfg.valid <= 1'b0;
		if (idx == REG_INVERSE_MODE) inv_mode = val[0];
		else begin
			size_code = val;
			frame_fill = 0;
		end
	endtask

	task automatic send_random(input int count);
		int sel;
		logic [15:0] re, im;
		for (int i = 0; i < count; i++) begin
			sel = int'($urandom_range(9));
			re = 16'($urandom);
			im = 16'($urandom);
			if (sel == 0) re = 16'h8000;
			if (sel == 1) im = 16'h7fff;
			if (sel == 2) begin
				re = 16'(int'($urandom_range(64)) - 32);
				im = 16'(int'($urandom_range(64)) - 32);
			end
			send_sample(re, im);
		end
	endtask

	task automatic test_directed();
		write_reg(REG_INVERSE_MODE, 3'd0);
		write_reg(REG_SIZE_LOG2, 3'd0);
		send_sample(16'h7fff, 16'h8000);
		send_sample(16'h8000, 16'h7fff);
		write_reg(REG_SIZE_LOG2, 3'd2);
		repeat (4) send_sample(16'h7fff, 16'h7fff);
		repeat (4) send_sample(16'h8000, 16'h8000);
		write_reg(REG_INVERSE_MODE, 3'd1);
		send_sample(16'h7fff, 16'h0000);
		send_sample(16'h8000, 16'hffff);
		send_sample(16'h0001, 16'h5555);
		send_sample(16'haaaa, 16'h8000);
		// partial frame discarded by a size write
		send_sample(16'h1234, 16'h4321);
		write_reg(REG_SIZE_LOG2, 3'd1);
		send_sample(16'h7fff, 16'h8000);
		// mode change mid-frame
		write_reg(REG_INVERSE_MODE, 3'd0);
		send_sample(16'h8000, 16'h7fff);
		write_reg(REG_SIZE_LOG2, 3'd7);
		send_random(64);
	endtask

	task automatic test_sizes();
		logic [2:0] sz;
		for (int f = 0; f < 6; f++) begin
			write_reg(REG_INVERSE_MODE, 3'($urandom_range(1)));
			sz = 3'($urandom_range(3));
			if (f == 5) sz = 3'd4;
			write_reg(REG_SIZE_LOG2, sz);
			send_random(1 << int'(sz));
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_SIZE_LOG2, 3'd2);
		hold_cycles = 300;
		send_random(16);
		wait_drained();
		send_random(8);
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		s_sample.valid = 1'b0;
		s_sample.payload = '0;
		sample_on = 1'b0;
		s_cfg.valid = 1'b0;
		s_cfg.payload = '0;
		m_bin.ready = 1'b0;
		inv_mode = 1'b0;
		size_code = 3'd6;
		frame_fill = 0;
		hold_cycles = 0;
		send_idle_pct = 30;
		recv_idle_pct = 45;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 45;
		recv_idle_pct = 30;
		test_sizes();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_sizes();
		test_backpressure();
		wait_drained();
		if (errors == 0) $display("[radix2_fft_ifft_unit] OK");
		else $display("[radix2_fft_ifft_unit] ERROR");
		$finish;
	end

	// long receiver hold-off
	initial begin
		recv_hold = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				recv_hold <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				recv_hold <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) m_bin.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		bin_t exp_bin;
		if (arst_n && m_bin.valid && m_bin.ready) begin
			if (bin_queue.size() == 0) begin
				$error("unexpected bin transaction %h", m_bin.payload);
				errors++;
			end else begin
				exp_bin = bin_queue.pop_front();
				if (m_bin.payload.bin_real !== exp_bin.bin_real) begin
					$error("bin_real expected %0d actual %0d", $signed(exp_bin.bin_real),
						$signed(m_bin.payload.bin_real));
					errors++;
				end
				if (m_bin.payload.bin_imag !== exp_bin.bin_imag) begin
					$error("bin_imag expected %0d actual %0d", $signed(exp_bin.bin_imag),
						$signed(m_bin.payload.bin_imag));
					errors++;
				end
				if (m_bin.payload.last_bin !== exp_bin.last_bin) begin
					$error("last_bin expected %0b actual %0b", exp_bin.last_bin,
						m_bin.payload.last_bin);
					errors++;
				end
			end
		end
	end

endmodule

>>> filelist.f
sv/r2fft_pkg.sv
sv/r2fft_if.sv
sv/r2fft_datapath.sv
sv/r2fft_ctrl.sv
sv/radix2_fft_ifft_unit.sv
sv/r2fft_checker.sv
test/radix2_fft_ifft_unit_test.sv
